[src/plcda_pkg.sv]
`timescale 1ns / 1ps
// Package: widths, device codes, status codes and the prefix decode table.
package plcda_pkg;

  localparam int ADDRESS_BITS = 24;
  localparam int MAX_CHARS    = 16;
  localparam int IDX_W        = $clog2(MAX_CHARS + 1);
  localparam int SUM_W        = ADDRESS_BITS + 5;
  localparam int START_W      = 24;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 72;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_SUBTYPE = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  localparam logic [7:0] DEV_M  = 8'h90;
  localparam logic [7:0] DEV_X  = 8'h9C;
  localparam logic [7:0] DEV_Y  = 8'h9D;
  localparam logic [7:0] DEV_D  = 8'hA8;
  localparam logic [7:0] DEV_W  = 8'hB4;
  localparam logic [7:0] DEV_L  = 8'h92;
  localparam logic [7:0] DEV_F  = 8'h93;
  localparam logic [7:0] DEV_V  = 8'h94;
  localparam logic [7:0] DEV_B  = 8'hA0;
  localparam logic [7:0] DEV_R  = 8'hAF;
  localparam logic [7:0] DEV_S  = 8'h98;
  localparam logic [7:0] DEV_Z  = 8'hCC;
  localparam logic [7:0] DEV_SN = 8'hC8;
  localparam logic [7:0] DEV_SS = 8'hC7;
  localparam logic [7:0] DEV_SC = 8'hC6;
  localparam logic [7:0] DEV_ZR = 8'hB0;
  localparam logic [7:0] DEV_TC = 8'hC0;
  localparam logic [7:0] DEV_TS = 8'hC1;
  localparam logic [7:0] DEV_TN = 8'hC2;
  localparam logic [7:0] DEV_CN = 8'hC5;
  localparam logic [7:0] DEV_CS = 8'hC4;
  localparam logic [7:0] DEV_CC = 8'hC3;

  localparam logic [7:0] CH_STAR = 8'h2A;

  typedef struct packed {
    logic [7:0] code;
    logic       type_flag;
    logic [7:0] second;
    logic       hex;
    status_e    status;
  } dev_t;

  function automatic dev_t mk_dev(input logic [7:0] code, input logic type_flag,
                                  input logic [7:0] second, input logic hex,
                                  input status_e status);
    dev_t d;
    d.code      = code;
    d.type_flag = type_flag;
    d.second    = second;
    d.hex       = hex;
    d.status    = status;
    return d;
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic dev_t dev_first(input logic [7:0] u);
    dev_t d;
    unique case (u) inside
      "M": d = mk_dev(DEV_M, 1'b1, CH_STAR, 1'b0, ST_OK);
      "X": d = mk_dev(DEV_X, 1'b1, CH_STAR, 1'b1, ST_OK);
      "Y": d = mk_dev(DEV_Y, 1'b1, CH_STAR, 1'b1, ST_OK);
      "D": d = mk_dev(DEV_D, 1'b1, CH_STAR, 1'b0, ST_OK);
      "W": d = mk_dev(DEV_W, 1'b0, CH_STAR, 1'b1, ST_OK);
      "L": d = mk_dev(DEV_L, 1'b1, CH_STAR, 1'b0, ST_OK);
      "F": d = mk_dev(DEV_F, 1'b1, CH_STAR, 1'b0, ST_OK);
      "V": d = mk_dev(DEV_V, 1'b1, CH_STAR, 1'b0, ST_OK);
      "B": d = mk_dev(DEV_B, 1'b1, CH_STAR, 1'b1, ST_OK);
      "R": d = mk_dev(DEV_R, 1'b1, CH_STAR, 1'b0, ST_OK);
      "S": d = mk_dev(DEV_S, 1'b1, CH_STAR, 1'b0, ST_OK);
      "Z": d = mk_dev(DEV_Z, 1'b0, CH_STAR, 1'b0, ST_OK);
      "T", "C": d = mk_dev(8'h00, 1'b0, CH_STAR, 1'b0, ST_SUBTYPE);
      default: d = mk_dev(8'h00, 1'b0, CH_STAR, 1'b0, ST_UNKNOWN);
    endcase
    return d;
  endfunction

endpackage

[src/plc_device_address_parser.sv]
`timescale 1ns / 1ps
// Top level: device address string parser, one character per word.
//
// Input stream carries one character of an address string (D100, X1A, TN5,
// ZR20, ...) per word, with tlast on the final character and the point count
// sampled on that word. A zero first character marks an empty string.
// Prefix letters are decoded in either case; the device number accumulates in
// radix 10 or 16, skips a hex 0x lead, stops at the first invalid character
// and saturates at the address width.
// Output stream carries one result word per string, registered in the cycle
// after the tlast word is taken; tuser holds the status code.
// Throughput is one character per cycle: the prefix decode and the
// multiply-by-10-or-16 plus digit are combinational between the parse state
// and the result register. The output register parts the two sides: input
// is taken whenever that register is empty or being drained, so a stalled
// receiver stops input only once a result is waiting.
// Reset clears the parse state and empties the output register; the next
// word is then the first character of a new string.
module plc_device_address_parser
  import plcda_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [7:0] char_in, [23:8] point_count
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [7:0] device_code, [8] type_flag, [16:9] prefix_first,
  // [24:17] prefix_second, [48:25] start_address, [64:49] count_out, zero above
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]            m_axis_tuser_o
);

  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [7:0]              first_q, first_d;
  dev_t                    dev_q, dev_d;
  logic [ADDRESS_BITS-1:0] acc_q, acc_d;
  logic                    stop_q, stop_d;
  logic                    out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0]   out_data_q, out_data_d;
  logic [1:0]              out_user_q, out_user_d;

  logic                    in_acc;
  logic [7:0]              c, u;
  logic [15:0]             count;
  logic [IDX_W-1:0]        dig_start, pos;
  logic                    is_dec, is_hex_lc, is_hex_uc, dig_ok, skip_x, run_digit;
  logic [3:0]              dval;
  logic [SUM_W-1:0]        ext, prod, sum;
  logic [ADDRESS_BITS-1:0] sat;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign c               = s_axis_tdata_i[7:0];
  assign count           = s_axis_tdata_i[23:8];
  assign u               = upcase(c);

  // digit path
  always_comb begin
    dig_start = (dev_q.second == CH_STAR) ? IDX_W'(1) : IDX_W'(2);
    pos       = idx_q - dig_start;
    is_dec    = (c >= "0") && (c <= "9");
    is_hex_lc = dev_q.hex && (c >= "a") && (c <= "f");
    is_hex_uc = dev_q.hex && (c >= "A") && (c <= "F");
    dig_ok    = is_dec || is_hex_lc || is_hex_uc;
    if (is_dec) begin
      dval = 4'(c - "0");
    end else if (is_hex_lc) begin
      dval = 4'(c - "a" + 8'd10);
    end else begin
      dval = 4'(c - "A" + 8'd10);
    end
    skip_x = dev_q.hex && (pos == IDX_W'(1)) && (acc_q == '0) && ((c == "x") || (c == "X"));
    ext    = SUM_W'(acc_q);
    prod   = dev_q.hex ? (ext << 4) : ((ext << 3) + (ext << 1));
    sum    = prod + SUM_W'(dval);
    sat    = (sum[SUM_W-1:ADDRESS_BITS] != '0) ? '1 : sum[ADDRESS_BITS-1:0];
  end

  always_comb begin
    idx_d       = idx_q;
    first_d     = first_q;
    dev_d       = dev_q;
    acc_d       = acc_q;
    stop_d      = stop_q;
    run_digit   = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;

    if (idx_q < IDX_W'(MAX_CHARS)) begin
      idx_d = idx_q + IDX_W'(1);
      if (idx_q == '0) begin
        if (c == 8'h00) begin
          dev_d.status = ST_EMPTY;
          first_d      = 8'h00;
        end else begin
          dev_d   = dev_first(u);
          first_d = u;
        end
      end else if (dev_q.status != ST_EMPTY) begin
        if (idx_q == IDX_W'(1)) begin
          if (dev_q.status != ST_UNKNOWN) begin
            case (first_q)
              "S": begin
                if (u == "N") begin
                  dev_d = mk_dev(DEV_SN, 1'b0, "N", 1'b0, dev_q.status);
                end else if (u == "S") begin
                  dev_d = mk_dev(DEV_SS, 1'b1, "S", 1'b0, dev_q.status);
                end else if (u == "C") begin
                  dev_d = mk_dev(DEV_SC, 1'b1, "C", 1'b0, dev_q.status);
                end else begin
                  run_digit = 1'b1;
                end
              end
              "Z": begin
                if (u == "R") begin
                  dev_d = mk_dev(DEV_ZR, 1'b0, "R", 1'b1, dev_q.status);
                end else begin
                  run_digit = 1'b1;
                end
              end
              "T": begin
                if (u == "C") begin
                  dev_d = mk_dev(DEV_TC, 1'b1, "C", 1'b0, ST_OK);
                end else if (u == "S") begin
                  dev_d = mk_dev(DEV_TS, 1'b1, "S", 1'b0, ST_OK);
                end else if (u == "N") begin
                  dev_d = mk_dev(DEV_TN, 1'b1, "N", 1'b0, ST_OK);
                end
              end
              "C": begin
                if (u == "N") begin
                  dev_d = mk_dev(DEV_CN, 1'b1, "N", 1'b0, ST_OK);
                end else if (u == "S") begin
                  dev_d = mk_dev(DEV_CS, 1'b1, "S", 1'b0, ST_OK);
                end else if (u == "C") begin
                  dev_d = mk_dev(DEV_CC, 1'b1, "C", 1'b0, ST_OK);
                end
              end
              default: begin
                run_digit = 1'b1;
              end
            endcase
          end
        end else begin
          run_digit = 1'b1;
        end
      end
    end

    if (run_digit && !stop_q && (dev_q.status == ST_OK) && !skip_x) begin
      if (dig_ok) begin
        acc_d = sat;
      end else begin
        stop_d = 1'b1;
      end
    end

    if (!in_acc) begin
      idx_d   = idx_q;
      first_d = first_q;
      dev_d   = dev_q;
      acc_d   = acc_q;
      stop_d  = stop_q;
    end else if (s_axis_tlast_i) begin
      out_valid_d = 1'b1;
      out_user_d  = dev_d.status;
      if (dev_d.status == ST_OK) begin
        out_data_d = {7'd0, count, START_W'(acc_d), dev_d.second, first_d,
                      dev_d.type_flag, dev_d.code};
      end else begin
        out_data_d = {7'd0, count, START_W'(0), 8'h00,
                      (dev_d.status == ST_EMPTY) ? 8'h00 : first_d, 1'b0, 8'h00};
      end
      idx_d   = '0;
      first_d = '0;
      dev_d   = '0;
      acc_d   = '0;
      stop_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      first_q     <= '0;
      dev_q       <= '0;
      acc_q       <= '0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      first_q     <= first_d;
      dev_q       <= dev_d;
      acc_q       <= acc_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tlast_i |=> m_axis_tvalid_o)
    else $error("result not presented after final character");

  a_last_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tlast_i |=> (idx_q == '0) && (acc_q == '0) && !stop_q)
    else $error("parse state not cleared after final character");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_W'(MAX_CHARS))
    else $error("character index beyond limit");

  a_error_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != ST_OK) |->
      (m_axis_tdata_o[8:0] == '0) && (m_axis_tdata_o[48:17] == '0))
    else $error("error result carries device fields");

  a_empty_no_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dev_q.status == ST_EMPTY) |-> (first_q == 8'h00))
    else $error("empty string holds a prefix letter");

endmodule
